// ===== rtl/signed_varint_codec_unit_macros.svh =====
// Assertion macros for the signed varint codec unit.
// Used by the top level only; no other dependencies.
`ifndef SIGNED_VARINT_CODEC_UNIT_MACROS_SVH
`define SIGNED_VARINT_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SVCU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVCU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/svcu_pkg.sv =====
// Shared types and constants of the signed varint codec unit.
// No dependencies.
package svcu_pkg;

   localparam int MAX_ENCODED_BYTES_DEF = 10;
   localparam int GROUP_BITS = 7;

   localparam logic [6:0] GROUP_ALL_ONES = 7'h7F;
   localparam logic [6:0] SHIFT_LIMIT    = 7'd70;
   localparam logic [6:0] SHIFT_STEP     = 7'd7;
   localparam logic [6:0] SHIFT_TOP      = 7'd63;
   localparam logic [6:0] SHIFT_WORD     = 7'd64;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   // One byte leaving the encoder.
   typedef struct packed {
      logic       emit;
      logic       last;
      logic [7:0] data;
   } enc_out_type;

   // One value leaving the decoder.
   typedef struct packed {
      logic               fire;
      logic               overlong;
      logic signed [63:0] value;
   } dec_out_type;

endpackage

// ===== rtl/svcu_enc.sv =====
// Encoder: 64-bit shift register that drops one 7-bit group per cycle while advance is high.
// Depends on svcu_pkg.
module svcu_enc #(
   parameter int MAX_ENCODED_BYTES = svcu_pkg::MAX_ENCODED_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [63:0]    value_in,
   input  logic                  advance,
   output logic                  busy,
   output svcu_pkg::enc_out_type enc_out
);

   localparam int CntWidth = $clog2(MAX_ENCODED_BYTES);
   localparam logic [CntWidth-1:0] CntLast = CntWidth'(MAX_ENCODED_BYTES - 1);

   logic                busy_ff, busy_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic signed [63:0]  val_ff, val_in;

   logic signed [63:0]  src;
   logic signed [63:0]  rest;
   logic [6:0]          group;
   logic [CntWidth-1:0] cnt_cur;
   logic                emit;
   logic                done;

   always_comb begin
      src     = busy_ff ? val_ff : value_in;
      cnt_cur = busy_ff ? cnt_ff : '0;
      emit    = busy_ff ? advance : start;
      group   = src[6:0];
      rest    = src >>> svcu_pkg::GROUP_BITS;
      done    = ((rest == 64'sd0) && !group[6]) ||
                ((rest == -64'sd1) && group[6]) ||
                (cnt_cur == CntLast);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      if (emit) begin
         busy_in = !done;
         cnt_in  = cnt_cur + CntWidth'(1);
         val_in  = rest;
      end
   end

   always_comb begin
      enc_out.emit = emit;
      enc_out.last = done;
      enc_out.data = {!done, group};
   end

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ===== rtl/svcu_dec.sv =====
// Decoder: merges one 7-bit group per accepted byte into the accumulator.
// Depends on svcu_pkg.
module svcu_dec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            byte_in,
   output svcu_pkg::dec_out_type dec_out
);

   logic [63:0] acc_ff, acc_in;
   logic [6:0]  shift_ff, shift_in;
   logic        ovl_ff, ovl_in;

   logic [6:0]  group;
   logic [63:0] acc_new;
   logic [6:0]  shift_sum;
   logic [6:0]  shift_new;
   logic        ovl_new;
   logic [63:0] ext_mask;
   logic        fire;

   always_comb begin
      group   = byte_in[6:0];
      acc_new = acc_ff;
      ovl_new = ovl_ff;
      if (shift_ff < svcu_pkg::SHIFT_TOP) begin
         acc_new = acc_ff | ({57'd0, group} << shift_ff[5:0]);
      end else if (shift_ff == svcu_pkg::SHIFT_TOP) begin
         acc_new = acc_ff | {group[0], 63'd0};
         // only pure sign extension may be dropped silently
         if ((group != 7'd0) && (group != svcu_pkg::GROUP_ALL_ONES)) begin
            ovl_new = 1'b1;
         end
      end else begin
         ovl_new = 1'b1;
      end
      shift_sum = shift_ff + svcu_pkg::SHIFT_STEP;
      shift_new = (shift_sum > svcu_pkg::SHIFT_LIMIT) ? svcu_pkg::SHIFT_LIMIT : shift_sum;
      ext_mask  = '0;
      if (group[6] && (shift_new < svcu_pkg::SHIFT_WORD)) begin
         ext_mask = ~64'd0 << shift_new[5:0];
      end
      fire = step && !byte_in[7];
   end

   always_comb begin
      acc_in   = acc_ff;
      shift_in = shift_ff;
      ovl_in   = ovl_ff;
      if (fire) begin
         acc_in   = '0;
         shift_in = '0;
         ovl_in   = 1'b0;
      end else if (step) begin
         acc_in   = acc_new;
         shift_in = shift_new;
         ovl_in   = ovl_new;
      end
   end

   always_comb begin
      dec_out.fire     = fire;
      dec_out.overlong = ovl_new;
      dec_out.value    = acc_new | ext_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         shift_ff <= '0;
         ovl_ff   <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         shift_ff <= shift_in;
         ovl_ff   <= ovl_in;
      end
   end

endmodule

// ===== rtl/signed_varint_codec_unit.sv =====
// Channel | Direction | Payload
// req_    | in        | cmd, value_in, byte_in
// rsp_    | out       | byte_out, value_out, is_value, last, overlong
//
// An encode yields 1 to 10 output bytes, the encoder shift register dropping
// one 7-bit group a cycle while the output is not stalled; the first byte leaves in
// the accept cycle. A decode byte is merged when accepted. Results pass an output
// register; a stalled result holds and input is stalled while it blocks.
// Reset is synchronous and clears the decoder and all valid state.
//
// Top level of the signed varint codec unit.
// Depends on svcu_pkg, svcu_enc, svcu_dec and the macro header.
`include "signed_varint_codec_unit_macros.svh"

module signed_varint_codec_unit #(
   parameter int MAX_ENCODED_BYTES = svcu_pkg::MAX_ENCODED_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [63:0] req_value_in,
   input  logic [7:0]         req_byte_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_byte_out,
   output logic signed [63:0] rsp_value_out,
   output logic               rsp_is_value,
   output logic               rsp_last,
   output logic               rsp_overlong
);

   svcu_pkg::enc_out_type enc_out;
   svcu_pkg::dec_out_type dec_out;

   logic enc_busy;
   logic out_free;
   logic req_accept;
   logic enc_start;
   logic dec_step;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic signed [63:0] value_ff, value_in;
   logic               is_value_ff, is_value_in;
   logic               last_ff, last_in;
   logic               overlong_ff, overlong_in;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = enc_busy || !out_free;
      req_accept = req_valid && !req_stall;
      enc_start  = req_accept && (req_cmd == svcu_pkg::CMD_ENCODE);
      dec_step   = req_accept && (req_cmd == svcu_pkg::CMD_DECODE);
   end

   svcu_enc #(
      .MAX_ENCODED_BYTES(MAX_ENCODED_BYTES)
   ) u_enc (
      .clock    (clock),
      .reset    (reset),
      .start    (enc_start),
      .value_in (req_value_in),
      .advance  (out_free),
      .busy     (enc_busy),
      .enc_out  (enc_out)
   );

   svcu_dec u_dec (
      .clock   (clock),
      .reset   (reset),
      .step    (dec_step),
      .byte_in (req_byte_in),
      .dec_out (dec_out)
   );

   always_comb begin
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      byte_in      = byte_ff;
      value_in     = value_ff;
      is_value_in  = is_value_ff;
      last_in      = last_ff;
      overlong_in  = overlong_ff;
      if (enc_out.emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = enc_out.data;
         value_in     = '0;
         is_value_in  = 1'b0;
         last_in      = enc_out.last;
         overlong_in  = 1'b0;
      end else if (dec_out.fire) begin
         rsp_valid_in = 1'b1;
         byte_in      = '0;
         value_in     = dec_out.value;
         is_value_in  = 1'b1;
         last_in      = 1'b1;
         overlong_in  = dec_out.overlong;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      value_ff    <= value_in;
      is_value_ff <= is_value_in;
      last_ff     <= last_in;
      overlong_ff <= overlong_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_byte_out  = byte_ff;
   assign rsp_value_out = value_ff;
   assign rsp_is_value  = is_value_ff;
   assign rsp_last      = last_ff;
   assign rsp_overlong  = overlong_ff;

   `SVCU_ASSERT_NOW(a_busy_stalls, clock, reset, enc_busy, req_stall, "input taken while encoding")
   `SVCU_ASSERT_NOW(a_one_source, clock, reset, enc_out.emit, !dec_out.fire,
      "encoder and decoder collide")
   `SVCU_ASSERT_NEXT(a_more_bytes, clock, reset, enc_out.emit && !enc_out.last, enc_busy,
      "encoder stopped early")
   `SVCU_ASSERT_NOW(a_value_last, clock, reset, rsp_valid && rsp_is_value,
      rsp_last && (rsp_byte_out == 8'd0), "bad decode result")

endmodule
